@@ sv/bbsf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bbsf_pkg;

	// Ring size of the byte store. Must be a power of two so the pointers wrap naturally.
	localparam int DEPTH = 1024;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the stream payloads.
	localparam int BYTE_W  = 8;
	localparam int ACT_W   = 2;
	localparam int LEN_W   = 11;
	localparam int TOTAL_W = 64;

	// Reset value of the capacity register.
	localparam int CAP_RESET = 1024;

	// Packed payload widths, rounded up to whole bytes.
	localparam int IN_W   = 24;
	localparam int OUT_W  = 168;
	localparam int OUT_PAD = OUT_W - (BYTE_W + 2 * LEN_W + 2 * TOTAL_W + 5);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLOSE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Access request from the queue control to the byte store.
	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic [PTR_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

@@ sv/bbsf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbsf_ram (
	input  wire logic                      clk,
	input  wire bbsf_pkg::mem_req_t        req,
	output logic [bbsf_pkg::BYTE_W-1:0]    rdata
);
	import bbsf_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	// Single write port; registered read returns the contents before a same-cycle write.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

@@ sv/bbsf_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bbsf_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bbsf_pkg::LEN_W-1:0]    capacity,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [bbsf_pkg::IN_W-1:0]     s_tdata,
	input  wire logic [bbsf_pkg::ACT_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [bbsf_pkg::OUT_W-1:0]         m_tdata,
	output bbsf_pkg::mem_req_t                 mem_req,
	input  wire logic [bbsf_pkg::BYTE_W-1:0]   mem_rdata
);
	import bbsf_pkg::*;

	// Queue state.
	logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic               closed_q, closed_d;
	logic [TOTAL_W-1:0] pushed_q, pushed_d;
	logic [TOTAL_W-1:0] popped_q, popped_d;

	// Status stage waiting for the head byte read.
	logic              valid_s1;
	logic              dropped_s1, dropped_d;
	logic              overrun_s1, overrun_d;
	logic              fwd_s1, fwd_d;
	logic [BYTE_W-1:0] fbyte_s1;

	logic              accept;
	logic              out_free;
	logic              move;
	action_t           act;
	logic [BYTE_W-1:0] push_byte;
	logic [LEN_W-1:0]  pop_count;
	logic [CNT_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  pop_n;
	logic [CNT_W-1:0]  space;
	logic              has_data;
	logic [BYTE_W-1:0] head;
	logic [OUT_W-1:0]  result;

	assign act       = action_t'(s_tuser);
	assign push_byte = s_tdata[BYTE_W-1:0];
	assign pop_count = s_tdata[BYTE_W +: LEN_W];

	// Handshake: a new transaction enters while the previous one moves to the output.
	assign out_free = !m_tvalid || m_tready;
	assign move     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	// Capacity is clamped to the ring size.
	assign cap_eff = (int'(capacity) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity);

	// Action decode and next queue state.
	always_comb begin
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		fill_d    = fill_q;
		closed_d  = closed_q;
		pushed_d  = pushed_q;
		popped_d  = popped_q;
		dropped_d = 1'b0;
		overrun_d = 1'b0;
		fwd_d     = 1'b0;
		pop_n     = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = wr_ptr_q;
		mem_req.wdata = push_byte;
		if (accept) begin
			unique case (act)
				ACT_PUSH: begin
					if (closed_q || fill_q >= cap_eff) begin
						dropped_d = 1'b1;
					end else begin
						mem_req.we = 1'b1;
						wr_ptr_d   = wr_ptr_q + PTR_W'(1);
						fill_d     = fill_q + CNT_W'(1);
						pushed_d   = pushed_q + TOTAL_W'(1);
						// The byte lands at the head of an empty queue.
						fwd_d      = (fill_q == '0);
					end
				end
				ACT_POP: begin
					if (int'(pop_count) > int'(fill_q)) begin
						overrun_d = 1'b1;
						pop_n     = fill_q;
					end else begin
						pop_n     = CNT_W'(pop_count);
					end
					rd_ptr_d = rd_ptr_q + pop_n[PTR_W-1:0];
					fill_d   = fill_q - pop_n;
					popped_d = popped_q + TOTAL_W'(pop_n);
				end
				ACT_CLOSE: begin
					closed_d = 1'b1;
				end
				default: begin
				end
			endcase
		end
		// The head byte is read at the pointer that follows this transaction.
		mem_req.raddr = rd_ptr_d;
	end

	// Queue state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
			closed_q <= 1'b0;
			pushed_q <= '0;
			popped_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			fill_q   <= fill_d;
			closed_q <= closed_d;
			pushed_q <= pushed_d;
			popped_q <= popped_d;
		end
	end

	// Status stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Status stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			dropped_s1 <= dropped_d;
			overrun_s1 <= overrun_d;
			fwd_s1     <= fwd_d;
			fbyte_s1   <= push_byte;
		end
	end

	// The queue registers still describe the staged transaction until the next one is taken,
	// which happens on the same edge that moves it out.
	assign has_data = (fill_q != '0);
	assign space    = (fill_q >= cap_eff) ? '0 : cap_eff - fill_q;
	assign head     = !has_data ? '0 : (fwd_s1 ? fbyte_s1 : mem_rdata);
	assign result   = {
		OUT_PAD'(0),
		overrun_s1,
		dropped_s1,
		closed_q && !has_data,
		closed_q,
		popped_q,
		pushed_q,
		LEN_W'(space),
		LEN_W'(fill_q),
		has_data,
		head
	};

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (move) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (move) begin
			m_tdata <= result;
		end
	end

`ifndef SYNTH
	// The fill level never exceeds the ring size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= DEPTH)
		else $error("fill level above ring size");

	// Pointer distance always equals the fill level modulo the ring size.
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(wr_ptr_q - rd_ptr_q) == fill_q[PTR_W-1:0])
		else $error("pointers disagree with fill level");

	// A staged transaction is kept while the output is blocked.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("staged transaction lost");

	// An accepted push grows the fill level by exactly one.
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_PUSH && !dropped_d |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("push did not advance fill level");

	// The queue state changes only when a transaction is taken.
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(fill_q) && $stable(rd_ptr_q) && $stable(wr_ptr_q))
		else $error("queue state changed without a transaction");
`endif

endmodule

`default_nettype wire

@@ sv/bounded_byte_stream_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte queue with a settable capacity and an end-of-stream mark. Each input transaction is a
// push of one byte, a pop of up to pop_count bytes, a close, or a no-op (action 3), and yields
// exactly one status transaction taken after the action. One transaction is accepted per clock
// cycle when the output is taken every cycle. Its status passes through the status stage, which
// waits for the registered read of the byte store that fetches the new head byte, and then
// through the output register before it is presented. Bytes live in a
// 1024-entry single-port-write RAM with a registered read; a byte pushed into an empty queue is
// forwarded to the head. The capacity register is written over the cfg channel, which is always
// ready, and must only be written while no transaction is in flight; values above 1024 act as
// 1024. The byte store has no reset: only written entries are ever reported.
module bounded_byte_stream_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration: capacity
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bbsf_pkg::LEN_W-1:0]    cfg_data,
	// Input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata: push_byte [7:0], pop_count [18:8], zero [23:19]
	input  wire logic [bbsf_pkg::IN_W-1:0]     s_tdata,
	// s_tuser: action [1:0]
	input  wire logic [bbsf_pkg::ACT_W-1:0]    s_tuser,
	// Output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: head_byte [7:0], head_valid [8], fill_level [19:9], space_left [30:20],
	// total_pushed [94:31], total_popped [158:95], stream_closed [159],
	// stream_finished [160], byte_dropped [161], pop_overrun [162], zero [167:163]
	output logic [bbsf_pkg::OUT_W-1:0]         m_tdata
);
	import bbsf_pkg::*;

	logic [LEN_W-1:0]  capacity_q;
	mem_req_t          mem_req;
	logic [BYTE_W-1:0] mem_rdata;

	// Capacity register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= LEN_W'(CAP_RESET);
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	bbsf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	bbsf_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import bbsf_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 3;
	localparam int TAIL_CYCLES   = 10;
	localparam int HOLD_CYCLES   = 120;
	localparam int PHASES        = 8;
	localparam int BACKLOG_BYTES = 40;

	// Status fields of one output transaction.
	typedef struct packed {
		logic [BYTE_W-1:0]  head_byte;
		logic               head_valid;
		logic [LEN_W-1:0]   fill_level;
		logic [LEN_W-1:0]   space_left;
		logic [TOTAL_W-1:0] total_pushed;
		logic [TOTAL_W-1:0] total_popped;
		logic               stream_closed;
		logic               stream_finished;
		logic               byte_dropped;
		logic               pop_overrun;
	} status_t;

	// One row of the directed plan: either a queue action or a capacity write.
	typedef struct packed {
		logic              is_cfg;
		action_t           act;
		logic [BYTE_W-1:0] push_byte;
		logic [LEN_W-1:0]  count;
		logic              typed;
		status_t           typed_status;
	} row_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LEN_W-1:0]   cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	// s_tdata: push_byte [7:0], pop_count [18:8], zero [23:19]
	logic [IN_W-1:0]    s_tdata   = '0;
	// s_tuser: action [1:0]
	logic [ACT_W-1:0]   s_tuser   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	// m_tdata: head_byte [7:0], head_valid [8], fill_level [19:9], space_left [30:20],
	// total_pushed [94:31], total_popped [158:95], stream_closed [159],
	// stream_finished [160], byte_dropped [161], pop_overrun [162], zero [167:163]
	logic [OUT_W-1:0]   m_tdata;

	// Mirror of the queue contents, counters and capacity register.
	logic [BYTE_W-1:0]  held_bytes[$];
	logic [TOTAL_W-1:0] pushed_sum   = '0;
	logic [TOTAL_W-1:0] popped_sum   = '0;
	logic               closed_seen  = 1'b0;
	logic [LEN_W-1:0]   capacity_reg = LEN_W'(CAP_RESET);

	status_t expected_status[$];
	row_t    plan[$];
	int      mismatches   = 0;
	int      results_seen = 0;
	bit      gaps_on      = 1'b1;
	int      hold_cycles  = 0;

	bounded_byte_stream_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one action to the mirror and returns the status it should report.
	function automatic status_t next_status(action_t act, logic [BYTE_W-1:0] pb,
			logic [LEN_W-1:0] cnt);
		status_t r;
		int unsigned eff;
		int unsigned n;
		r = '0;
		eff = (int'(capacity_reg) > DEPTH) ? DEPTH : 32'(capacity_reg);
		case (act)
			ACT_PUSH: begin
				if (closed_seen || held_bytes.size() >= eff) begin
					r.byte_dropped = 1'b1;
				end else begin
					held_bytes.push_back(pb);
					pushed_sum++;
				end
			end
			ACT_POP: begin
				n = 32'(cnt);
				if (n > held_bytes.size()) begin
					r.pop_overrun = 1'b1;
					n = held_bytes.size();
				end
				repeat (n) void'(held_bytes.pop_front());
				popped_sum += TOTAL_W'(n);
			end
			ACT_CLOSE: begin
				closed_seen = 1'b1;
			end
			default: begin
			end
		endcase
		r.head_valid = held_bytes.size() != 0;
		r.head_byte = r.head_valid ? held_bytes[0] : '0;
		r.fill_level = LEN_W'(held_bytes.size());
		r.space_left = (held_bytes.size() >= eff) ? '0 : LEN_W'(eff - held_bytes.size());
		r.total_pushed = pushed_sum;
		r.total_popped = popped_sum;
		r.stream_closed = closed_seen;
		r.stream_finished = closed_seen && !r.head_valid;
		return r;
	endfunction

	function automatic status_t unpack_status(logic [OUT_W-1:0] d);
		status_t s;
		s.head_byte = d[7:0];
		s.head_valid = d[8];
		s.fill_level = d[19:9];
		s.space_left = d[30:20];
		s.total_pushed = d[94:31];
		s.total_popped = d[158:95];
		s.stream_closed = d[159];
		s.stream_finished = d[160];
		s.byte_dropped = d[161];
		s.pop_overrun = d[162];
		return s;
	endfunction

	function automatic status_t status_of(logic [7:0] hb, logic hv, logic [10:0] buffered,
			logic [10:0] space, logic [63:0] pushed, logic [63:0] popped, logic closed,
			logic finished, logic dropped, logic overrun);
		status_t s;
		s.head_byte = hb;
		s.head_valid = hv;
		s.fill_level = buffered;
		s.space_left = space;
		s.total_pushed = pushed;
		s.total_popped = popped;
		s.stream_closed = closed;
		s.stream_finished = finished;
		s.byte_dropped = dropped;
		s.pop_overrun = overrun;
		return s;
	endfunction

	function automatic row_t item_row(action_t act, logic [7:0] pb, logic [10:0] cnt);
		row_t r;
		r = '0;
		r.act = act;
		r.push_byte = pb;
		r.count = cnt;
		return r;
	endfunction

	function automatic row_t typed_row(action_t act, logic [7:0] pb, logic [10:0] cnt,
			status_t st);
		row_t r;
		r = item_row(act, pb, cnt);
		r.typed = 1'b1;
		r.typed_status = st;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [10:0] value);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.count = value;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] seen);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %0h, got %0h", results_seen, what, want, seen);
	endtask

	// Compares one output transaction with the oldest outstanding status.
	task automatic check_status(status_t got);
		status_t want;
		results_seen++;
		if (expected_status.size() == 0) begin
			note_mismatch("transaction with nothing outstanding, head_byte", '0, got.head_byte);
		end else begin
			want = expected_status.pop_front();
			if (got.head_byte !== want.head_byte)
				note_mismatch("head_byte", want.head_byte, got.head_byte);
			if (got.head_valid !== want.head_valid)
				note_mismatch("head_valid", want.head_valid, got.head_valid);
			if (got.fill_level !== want.fill_level)
				note_mismatch("fill_level", want.fill_level, got.fill_level);
			if (got.space_left !== want.space_left)
				note_mismatch("space_left", want.space_left, got.space_left);
			if (got.total_pushed !== want.total_pushed)
				note_mismatch("total_pushed", want.total_pushed, got.total_pushed);
			if (got.total_popped !== want.total_popped)
				note_mismatch("total_popped", want.total_popped, got.total_popped);
			if (got.stream_closed !== want.stream_closed)
				note_mismatch("stream_closed", want.stream_closed, got.stream_closed);
			if (got.stream_finished !== want.stream_finished)
				note_mismatch("stream_finished", want.stream_finished, got.stream_finished);
			if (got.byte_dropped !== want.byte_dropped)
				note_mismatch("byte_dropped", want.byte_dropped, got.byte_dropped);
			if (got.pop_overrun !== want.pop_overrun)
				note_mismatch("pop_overrun", want.pop_overrun, got.pop_overrun);
		end
	endtask

	// Offers one input transaction and records its status once it is taken.
	task automatic send_item(action_t act, logic [7:0] pb, logic [10:0] cnt, logic typed,
			status_t typed_st);
		int gap;
		status_t st;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, cnt, pb};
		do @(posedge clk); while (!s_tready);
		st = next_status(act, pb, cnt);
		expected_status.push_back(typed ? typed_st : st);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
	endtask

	// Capacity writes happen only with nothing in flight.
	task automatic set_capacity(logic [10:0] value);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_reg = value;
	endtask

	task automatic run_row(row_t r);
		if (r.is_cfg)
			set_capacity(r.count);
		else
			send_item(r.act, r.push_byte, r.count, r.typed, r.typed_status);
	endtask

	// Pushes at the given percentage and mostly short pops, with exact-fill and random-length pops
	task automatic random_items(int n, int push_pct, bit allow_close);
		int pick;
		int sub;
		action_t act;
		logic [10:0] cnt;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			cnt = LEN_W'($urandom_range(0, 2047));
			if (pick < push_pct) begin
				act = ACT_PUSH;
			end else if (pick < 92) begin
				act = ACT_POP;
				sub = $urandom_range(0, 9);
				if (sub < 6)
					cnt = LEN_W'($urandom_range(0, 4));
				else if (sub < 8)
					cnt = LEN_W'(held_bytes.size());
			end else if (allow_close && pick < 96) begin
				act = ACT_CLOSE;
			end else begin
				act = ACT_NONE;
			end
			send_item(act, BYTE_W'($urandom_range(0, 255)), cnt, 1'b0, '0);
		end
	endtask

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin : take_results
		int gap;
		forever begin
			if (hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				gap = gaps_on ? $urandom_range(0, 5) : 0;
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_status(unpack_status(m_tdata));
		end
	end

	// Ends the run when no transaction of any kind completes for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int close_start;
		int phase_cap[PHASES];
		int phase_push[PHASES];

		// Opening rows start from the reset state with the full capacity.
		plan.push_back(typed_row(ACT_NONE, 8'h00, 11'd0,
			status_of(8'h00, 1'b0, 11'd0, 11'd1024, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(ACT_POP, 8'h00, 11'd0,
			status_of(8'h00, 1'b0, 11'd0, 11'd1024, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(ACT_POP, 8'h00, 11'd2047,
			status_of(8'h00, 1'b0, 11'd0, 11'd1024, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(typed_row(ACT_PUSH, 8'hFF, 11'd0,
			status_of(8'hFF, 1'b1, 11'd1, 11'd1023, 64'd1, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(ACT_PUSH, 8'h00, 11'd0,
			status_of(8'hFF, 1'b1, 11'd2, 11'd1022, 64'd2, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(ACT_POP, 8'h00, 11'd1,
			status_of(8'h00, 1'b1, 11'd1, 11'd1023, 64'd2, 64'd1, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan.push_back(typed_row(ACT_POP, 8'h00, 11'd5,
			status_of(8'h00, 1'b0, 11'd0, 11'd1024, 64'd2, 64'd2, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(item_row(ACT_PUSH, 8'hA5, 11'd0));
		plan.push_back(item_row(ACT_PUSH, 8'h5A, 11'd0));
		plan.push_back(item_row(ACT_PUSH, 8'h3C, 11'd0));
		plan.push_back(item_row(ACT_NONE, 8'hFF, 11'd2047));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd0));
		// Capacity lowered below the fill level, then pushes against a full queue.
		plan.push_back(cfg_row(11'd2));
		plan.push_back(item_row(ACT_PUSH, 8'h11, 11'd0));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd2));
		plan.push_back(item_row(ACT_PUSH, 8'h22, 11'd0));
		plan.push_back(item_row(ACT_PUSH, 8'h33, 11'd0));
		// Zero capacity drops everything; capacity above the ring size acts as the ring size.
		plan.push_back(cfg_row(11'd0));
		plan.push_back(item_row(ACT_PUSH, 8'h44, 11'd0));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd1024));
		plan.push_back(cfg_row(11'd2047));
		plan.push_back(item_row(ACT_PUSH, 8'h55, 11'd0));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd1));
		plan.push_back(cfg_row(11'd1024));
		// End of stream: repeated close, refused push, and draining after the close.
		close_start = plan.size();
		plan.push_back(item_row(ACT_PUSH, 8'h66, 11'd0));
		plan.push_back(item_row(ACT_CLOSE, 8'h00, 11'd0));
		plan.push_back(item_row(ACT_PUSH, 8'h77, 11'd0));
		plan.push_back(item_row(ACT_CLOSE, 8'h00, 11'd0));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd1));
		plan.push_back(item_row(ACT_NONE, 8'h00, 11'd0));
		plan.push_back(item_row(ACT_POP, 8'h00, 11'd2047));
		plan.push_back(item_row(ACT_NONE, 8'h00, 11'd0));

		phase_cap  = '{16, 3, 1, 0, 2047, 1025, 7, 1024};
		phase_push = '{80, 60, 55, 50, 70, 60, 55, 50};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < close_start; i++)
			run_row(plan[i]);

		// Build a backlog under the full capacity, push a few more, then empty it with one oversized pop.
		while (held_bytes.size() < BACKLOG_BYTES)
			send_item(ACT_PUSH, BYTE_W'($urandom_range(0, 255)),
				LEN_W'($urandom_range(0, 2047)), 1'b0, '0);
		repeat (3) send_item(ACT_PUSH, BYTE_W'($urandom_range(0, 255)), 11'd0, 1'b0, '0);
		send_item(ACT_POP, 8'h00, 11'd2047, 1'b0, '0);

		for (int p = 0; p < PHASES; p++) begin
			set_capacity(LEN_W'(phase_cap[p]));
			gaps_on = (p != 4) && (p != 6);
			if (p == 6)
				hold_cycles = HOLD_CYCLES;
			random_items(20, phase_push[p], 1'b0);
			if (p == 2)
				wait_all_results();
			random_items(20, phase_push[p], 1'b0);
		end

		gaps_on = 1'b1;
		for (int i = close_start; i < plan.size(); i++)
			run_row(plan[i]);
		random_items(20, 30, 1'b1);

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
sv/bbsf_pkg.sv
sv/bbsf_ram.sv
sv/bbsf_core.sv
sv/bounded_byte_stream_fifo.sv
bench/tb.sv
